>>> rtl/i2cebm_pkg.sv
// Shared types and constants for the I2C EEPROM byte master.
`default_nettype none

package i2cebm_pkg;

    // Request codes carried in the op field.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic CFG_ACK_TIMEOUT    = 1'b1;

    localparam int unsigned BITS_PER_BYTE = 8;

    // Register reset values.
    localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'd80;
    localparam logic [7:0] ACK_TIMEOUT_RESET    = 8'd255;

    // Bus sequence steps; the two unused codes fall back to idle.
    typedef enum logic [3:0] {
        ST_IDLE     = 4'd0,
        ST_START_A  = 4'd1,
        ST_DEVW     = 4'd2,
        ST_DEVW_ACK = 4'd3,
        ST_ADDR     = 4'd4,
        ST_ADDR_ACK = 4'd5,
        ST_DATA     = 4'd6,
        ST_DATA_ACK = 4'd7,
        ST_START_B  = 4'd8,
        ST_DEVR     = 4'd9,
        ST_DEVR_ACK = 4'd10,
        ST_READ     = 4'd11,
        ST_NACK     = 4'd12,
        ST_STOP     = 4'd13
    } step_t;

    // Input item as unpacked from the slave-side tdata.
    typedef struct packed {
        logic       sda_in;
        logic [7:0] write_data;
        logic [7:0] mem_addr;
        logic [1:0] op;
    } tick_in_t;

    // Result item, lowest field in the lowest bits.
    typedef struct packed {
        logic       no_ack;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_out;
        logic       scl;
    } tick_out_t;

endpackage

`default_nettype wire

>>> rtl/i2cebm_core.sv
// Bus sequencer: advances the I2C transfer by one tick per accepted item.
`default_nettype none

module i2cebm_core
    import i2cebm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire tick_in_t   tick_in,
    input  wire logic [6:0] device_address,
    input  wire logic [7:0] ack_timeout,
    output tick_out_t       tick_out
);

    step_t      step_reg, step_next;
    logic [1:0] phase_reg, phase_next;
    logic [3:0] bit_index_reg, bit_index_next;
    logic [7:0] shift_reg, shift_next;
    logic       is_read_reg, is_read_next;
    logic [7:0] addr_hold_reg, addr_hold_next;
    logic [7:0] data_hold_reg, data_hold_next;
    logic [7:0] ack_wait_reg, ack_wait_next;
    logic [7:0] received_reg, received_next;
    logic       ack_missed_reg, ack_missed_next;

    logic       scl;
    logic       sda;
    logic       done;
    logic       do_enter;
    logic       keep_shift;
    step_t      enter_step;
    step_t      ack_target;
    step_t      byte_ack_step;
    logic [3:0] bit_count;

    assign bit_count = bit_index_reg + 4'd1;

    // Step that follows an acknowledge phase.
    always_comb
    begin
        case (step_reg)
            ST_DEVW_ACK: ack_target = ST_ADDR;
            ST_ADDR_ACK: ack_target = is_read_reg ? ST_START_B : ST_DATA;
            ST_DATA_ACK: ack_target = ST_STOP;
            default:     ack_target = ST_READ;
        endcase
    end

    // Acknowledge step that follows each transmitted byte.
    always_comb
    begin
        case (step_reg)
            ST_DEVW: byte_ack_step = ST_DEVW_ACK;
            ST_ADDR: byte_ack_step = ST_ADDR_ACK;
            ST_DATA: byte_ack_step = ST_DATA_ACK;
            default: byte_ack_step = ST_DEVR_ACK;
        endcase
    end

    always_comb
    begin
        step_next       = step_reg;
        phase_next      = phase_reg;
        bit_index_next  = bit_index_reg;
        shift_next      = shift_reg;
        is_read_next    = is_read_reg;
        addr_hold_next  = addr_hold_reg;
        data_hold_next  = data_hold_reg;
        ack_wait_next   = ack_wait_reg;
        received_next   = received_reg;
        ack_missed_next = ack_missed_reg;
        scl             = 1'b1;
        sda             = 1'b1;
        done            = 1'b0;
        do_enter        = 1'b0;
        keep_shift      = 1'b0;
        enter_step      = ST_IDLE;

        case (step_reg)
            ST_IDLE:
            begin
                if (tick_in.op == OP_WRITE || tick_in.op == OP_READ)
                begin
                    is_read_next    = (tick_in.op == OP_READ);
                    addr_hold_next  = tick_in.mem_addr;
                    data_hold_next  = tick_in.write_data;
                    ack_missed_next = 1'b0;
                    do_enter        = 1'b1;
                    enter_step      = ST_START_A;
                end
            end
            ST_START_A, ST_START_B:
            begin
                if (phase_reg == 2'd0)
                begin
                    scl        = 1'b0;
                    phase_next = 2'd1;
                end
                else if (phase_reg == 2'd1)
                begin
                    phase_next = 2'd2;
                end
                else
                begin
                    sda        = 1'b0;
                    do_enter   = 1'b1;
                    enter_step = (step_reg == ST_START_A) ? ST_DEVW : ST_DEVR;
                end
            end
            ST_DEVW, ST_ADDR, ST_DATA, ST_DEVR:
            begin
                sda = shift_reg[7];
                if (phase_reg == 2'd0)
                begin
                    scl        = 1'b0;
                    phase_next = 2'd1;
                end
                else
                begin
                    shift_next     = {shift_reg[6:0], 1'b0};
                    phase_next     = 2'd0;
                    bit_index_next = bit_count;
                    if (bit_count >= 4'(BITS_PER_BYTE))
                    begin
                        do_enter   = 1'b1;
                        enter_step = byte_ack_step;
                    end
                end
            end
            ST_DEVW_ACK, ST_ADDR_ACK, ST_DATA_ACK, ST_DEVR_ACK:
            begin
                if (phase_reg == 2'd0)
                begin
                    scl        = 1'b0;
                    phase_next = 2'd1;
                end
                else if (!tick_in.sda_in)
                begin
                    do_enter   = 1'b1;
                    enter_step = ack_target;
                end
                else if (ack_wait_reg >= ack_timeout)
                begin
                    // Timed out: note it and carry on with the transfer.
                    ack_missed_next = 1'b1;
                    do_enter        = 1'b1;
                    enter_step      = ack_target;
                end
                else
                begin
                    ack_wait_next = ack_wait_reg + 8'd1;
                end
            end
            ST_READ:
            begin
                if (phase_reg == 2'd0)
                begin
                    scl        = 1'b0;
                    phase_next = 2'd1;
                end
                else
                begin
                    shift_next     = {shift_reg[6:0], tick_in.sda_in};
                    phase_next     = 2'd0;
                    bit_index_next = bit_count;
                    if (bit_count >= 4'(BITS_PER_BYTE))
                    begin
                        do_enter   = 1'b1;
                        keep_shift = 1'b1;
                        enter_step = ST_NACK;
                    end
                end
            end
            ST_NACK:
            begin
                if (phase_reg == 2'd0)
                begin
                    scl        = 1'b0;
                    phase_next = 2'd1;
                end
                else
                begin
                    do_enter   = 1'b1;
                    keep_shift = 1'b1;
                    enter_step = ST_STOP;
                end
            end
            ST_STOP:
            begin
                if (phase_reg == 2'd0)
                begin
                    scl        = 1'b0;
                    sda        = 1'b0;
                    phase_next = 2'd1;
                end
                else if (phase_reg == 2'd1)
                begin
                    sda        = 1'b0;
                    phase_next = 2'd2;
                end
                else
                begin
                    done           = 1'b1;
                    step_next      = ST_IDLE;
                    phase_next     = 2'd0;
                    bit_index_next = 4'd0;
                    ack_wait_next  = 8'd0;
                    if (is_read_reg)
                    begin
                        received_next = shift_reg;
                    end
                end
            end
            default:
            begin
                step_next      = ST_IDLE;
                phase_next     = 2'd0;
                bit_index_next = 4'd0;
                ack_wait_next  = 8'd0;
            end
        endcase

        if (do_enter)
        begin
            step_next      = enter_step;
            phase_next     = 2'd0;
            bit_index_next = 4'd0;
            ack_wait_next  = 8'd0;
            if (!keep_shift)
            begin
                case (enter_step)
                    ST_DEVW: shift_next = {device_address, 1'b0};
                    ST_DEVR: shift_next = {device_address, 1'b1};
                    ST_ADDR: shift_next = addr_hold_reg;
                    ST_DATA: shift_next = data_hold_reg;
                    ST_READ: shift_next = 8'd0;
                    default: shift_next = shift_next;
                endcase
            end
        end
    end

    always_comb
    begin
        tick_out.scl       = scl;
        tick_out.sda_out   = sda;
        tick_out.busy_res  = (step_next != ST_IDLE);
        tick_out.done_res  = done;
        tick_out.read_data = received_next;
        tick_out.no_ack    = ack_missed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= ST_IDLE;
            phase_reg      <= 2'd0;
            bit_index_reg  <= 4'd0;
            shift_reg      <= 8'd0;
            is_read_reg    <= 1'b0;
            addr_hold_reg  <= 8'd0;
            data_hold_reg  <= 8'd0;
            ack_wait_reg   <= 8'd0;
            received_reg   <= 8'd0;
            ack_missed_reg <= 1'b0;
        end
        else if (advance)
        begin
            step_reg       <= step_next;
            phase_reg      <= phase_next;
            bit_index_reg  <= bit_index_next;
            shift_reg      <= shift_next;
            is_read_reg    <= is_read_next;
            addr_hold_reg  <= addr_hold_next;
            data_hold_reg  <= data_hold_next;
            ack_wait_reg   <= ack_wait_next;
            received_reg   <= received_next;
            ack_missed_reg <= ack_missed_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2c_eeprom_byte_master_unit.sv
// Top level of the I2C EEPROM byte master: stream ports, registers, result stage.
//
// Usage: every transaction on the slave-side stream is one bus timing tick.
// It carries the sampled SDA level and may carry a request (byte write or
// random read) that is taken only while the master is idle. For every input
// transaction exactly one result transaction appears on the master-side
// stream with the SCL and SDA levels to drive for that tick, the busy and
// done flags, the byte of the last completed read and the no-acknowledge flag.
// The result of a tick is presented in the cycle after it is accepted. Throughput
// is one tick per clock cycle while the receiver keeps taking results, set by the
// single sequencer update that sits between acceptance and the result register.
// The result register holds one result; a new tick is accepted whenever that
// register is empty or is being emptied in the same cycle, so a stalled
// receiver simply holds off the input with s_axis_tready low and nothing is
// dropped. The device address and acknowledge timeout are written through the cfg port,
// by the user only while no transfer is in flight; the block does not enforce it.
// Reset (rst_n low) returns the sequencer to idle, empties the result
// register and restores the device address to 80 and the timeout to 255.
`default_nettype none

module i2c_eeprom_byte_master_unit
    import i2cebm_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Fields from bit 0: op[1:0], mem_addr[9:2], write_data[17:10], sda_in[18], zero pad.
    input  wire logic [23:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Fields from bit 0: scl[0], sda_out[1], busy_res[2], done_res[3],
    // read_data[11:4], no_ack[12], zero pad.
    output logic [15:0]      m_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic [6:0] device_address_reg;
    logic [7:0] ack_timeout_reg;
    logic       out_valid_reg, out_valid_next;
    tick_out_t  out_data_reg;
    tick_out_t  core_out;
    tick_in_t   tick_in;
    logic       accept;

    assign tick_in       = s_axis_tdata[$bits(tick_in_t)-1:0];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= DEVICE_ADDRESS_RESET;
            ack_timeout_reg    <= ACK_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: device_address_reg <= cfg_data[6:0];
                CFG_ACK_TIMEOUT:    ack_timeout_reg    <= cfg_data;
                default:            ack_timeout_reg    <= ack_timeout_reg;
            endcase
        end
    end

    i2cebm_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (accept),
        .tick_in        (tick_in),
        .device_address (device_address_reg),
        .ack_timeout    (ack_timeout_reg),
        .tick_out       (core_out)
    );

    // Result stage: loaded on every accepted tick, emptied by the receiver.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= core_out;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16 - $bits(tick_out_t)){1'b0}}, out_data_reg};

endmodule

`default_nettype wire

>>> dv/i2c_eeprom_byte_master_unit_tb.sv
// Self-checking stream testbench for the I2C EEPROM byte master with a built-in bus tick predictor.
module i2c_eeprom_byte_master_unit_tb;
    import i2cebm_pkg::*;

    // The op field has one spare code; the block must treat it as a plain tick.
    localparam logic [1:0] OP_SPARE = 2'd3;
    // Receiver hold-off used to fill the block and back-pressure the input side.
    localparam int HOLD_CYCLES = 300;
    // Generous ceiling on the whole run, far above the slowest legal schedule.
    localparam int unsigned CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = '0;

    i2c_eeprom_byte_master_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ticks waiting to be offered on the input stream, and the bus levels
    // that the predictor expects on the output stream, oldest first.
    tick_in_t  tick_feed[$];
    tick_out_t line_states[$];

    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Idling control. Bursts of idling are allowed only while gaps_on is set;
    // it is redrawn at random by the watchdog so that there are quiet stretches too.
    // calm switches all idling off for the last part of the run.
    logic gaps_on = 1'b1;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   send_gap = 0;
    int   recv_gap = 0;
    int   hold_left = 0;

    // Predictor copy of the configuration registers.
    logic [6:0] dev_addr = DEVICE_ADDRESS_RESET;
    logic [7:0] ack_limit = ACK_TIMEOUT_RESET;

    // Predictor copy of the sequencer state.
    step_t      bus_step = ST_IDLE;
    logic [1:0] tick_ph = '0;
    logic [3:0] bit_cnt = '0;
    logic [7:0] shreg = '0;
    logic       rd_mode = 1'b0;
    logic [7:0] addr_q = '0;
    logic [7:0] data_q = '0;
    logic [7:0] ack_cnt = '0;
    logic [7:0] rx_byte = '0;
    logic       nack_flag = 1'b0;

    // Moving into a new step restarts the tick phase, the bit count and the
    // acknowledge wait, and loads the byte that the step will shift out.
    function automatic void enter_step(step_t s);
        bus_step = s;
        tick_ph  = '0;
        bit_cnt  = '0;
        ack_cnt  = '0;
        case (s)
            ST_DEVW: shreg = {dev_addr, 1'b0};
            ST_DEVR: shreg = {dev_addr, 1'b1};
            ST_ADDR: shreg = addr_q;
            ST_DATA: shreg = data_q;
            ST_READ: shreg = '0;
            default: ;
        endcase
    endfunction

    // Where the sequence goes once an acknowledge phase is over. The address
    // acknowledge of a read branches into the repeated start.
    function automatic step_t after_ack(step_t s);
        case (s)
            ST_DEVW_ACK: return ST_ADDR;
            ST_ADDR_ACK: return rd_mode ? ST_START_B : ST_DATA;
            ST_DATA_ACK: return ST_STOP;
            default:     return ST_READ;
        endcase
    endfunction

    // One bus timing tick: advances the sequencer copy and returns the line
    // levels and flags that the block must report for this tick.
    function automatic tick_out_t advance_bus(tick_in_t t);
        tick_out_t  r;
        step_t      s;
        logic [7:0] keep;
        s = bus_step;
        r = '0;
        r.scl = 1'b1;
        r.sda_out = 1'b1;
        case (s)
            ST_IDLE:
            begin
                // Only a write or read request starts a transfer; the spare
                // code and plain ticks leave the bus released.
                if (t.op == OP_WRITE || t.op == OP_READ)
                begin
                    rd_mode   = (t.op == OP_READ);
                    addr_q    = t.mem_addr;
                    data_q    = t.write_data;
                    nack_flag = 1'b0;
                    enter_step(ST_START_A);
                end
            end
            ST_START_A, ST_START_B:
            begin
                if (tick_ph == 2'd0)
                begin
                    r.scl = 1'b0;
                    tick_ph = 2'd1;
                end
                else if (tick_ph == 2'd1)
                    tick_ph = 2'd2;
                else
                begin
                    r.sda_out = 1'b0;
                    enter_step(s == ST_START_A ? ST_DEVW : ST_DEVR);
                end
            end
            ST_DEVW, ST_ADDR, ST_DATA, ST_DEVR:
            begin
                r.sda_out = shreg[7];
                if (tick_ph == 2'd0)
                begin
                    r.scl = 1'b0;
                    tick_ph = 2'd1;
                end
                else
                begin
                    shreg   = {shreg[6:0], 1'b0};
                    tick_ph = 2'd0;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                        enter_step(step_t'(s + 4'd1));
                end
            end
            ST_DEVW_ACK, ST_ADDR_ACK, ST_DATA_ACK, ST_DEVR_ACK:
            begin
                // SCL stays high until the slave pulls SDA low or the wait
                // reaches the timeout; a timeout latches the no-ack flag.
                if (tick_ph == 2'd0)
                begin
                    r.scl = 1'b0;
                    tick_ph = 2'd1;
                end
                else if (!t.sda_in)
                    enter_step(after_ack(s));
                else if (ack_cnt >= ack_limit)
                begin
                    nack_flag = 1'b1;
                    enter_step(after_ack(s));
                end
                else
                    ack_cnt = ack_cnt + 8'd1;
            end
            ST_READ:
            begin
                if (tick_ph == 2'd0)
                begin
                    r.scl = 1'b0;
                    tick_ph = 2'd1;
                end
                else
                begin
                    shreg   = {shreg[6:0], t.sda_in};
                    tick_ph = 2'd0;
                    bit_cnt = bit_cnt + 4'd1;
                    if (bit_cnt >= 4'd8)
                    begin
                        keep = shreg;
                        enter_step(ST_NACK);
                        shreg = keep;
                    end
                end
            end
            ST_NACK:
            begin
                // The received byte rides along through the NACK clock and
                // the stop until it is published.
                if (tick_ph == 2'd0)
                begin
                    r.scl = 1'b0;
                    tick_ph = 2'd1;
                end
                else
                begin
                    keep = shreg;
                    enter_step(ST_STOP);
                    shreg = keep;
                end
            end
            ST_STOP:
            begin
                if (tick_ph == 2'd0)
                begin
                    r.scl = 1'b0;
                    r.sda_out = 1'b0;
                    tick_ph = 2'd1;
                end
                else if (tick_ph == 2'd1)
                begin
                    r.sda_out = 1'b0;
                    tick_ph = 2'd2;
                end
                else
                begin
                    r.done_res = 1'b1;
                    if (rd_mode)
                        rx_byte = shreg;
                    bus_step = ST_IDLE;
                    tick_ph  = '0;
                    bit_cnt  = '0;
                    ack_cnt  = '0;
                end
            end
            default:
            begin
                bus_step = ST_IDLE;
                tick_ph  = '0;
                bit_cnt  = '0;
                ack_cnt  = '0;
            end
        endcase
        r.busy_res  = (bus_step != ST_IDLE);
        r.read_data = rx_byte;
        r.no_ack    = nack_flag;
        return r;
    endfunction

    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Every output transaction is matched against the oldest expectation.
    task automatic compare_line_state(logic [15:0] raw);
        tick_out_t got;
        tick_out_t want;
        got = tick_out_t'(raw[12:0]);
        if (line_states.size() == 0)
        begin
            $display("%0t: result with nothing expected, expected none, actual %h", $time, raw);
            mismatch_count++;
        end
        else
        begin
            want = line_states.pop_front();
            compare_field("scl", 8'(want.scl), 8'(got.scl));
            compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("no_ack", 8'(want.no_ack), 8'(got.no_ack));
        end
    endtask

    // Input driver. The accepted transaction is run through the predictor at
    // the edge where it is taken, then the next tick from the feed is put up
    // unless an idle burst is in progress. Data stays stable while stalled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                line_states.push_back(advance_bus(tick_in_t'(s_axis_tdata[18:0])));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap == 0 && !calm && gaps_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 14);
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (tick_feed.size() > 0)
                begin
                    s_axis_tdata  <= {5'b0, tick_feed.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output monitor. It checks each taken result and drives tready with
    // random stall bursts, plus one long hold-off on request from the
    // sequence so that the result register fills and the input side stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                compare_line_state(m_axis_tdata);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (recv_gap == 0 && hold_left == 0 && !calm && gaps_on && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 14);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Watchdog, and the slow redraw of whether idle bursts are allowed.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0)
            gaps_on <= ($urandom_range(0, 3) != 0);
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic pick_sda(int ones_in_8);
        return $urandom_range(0, 7) < ones_in_8;
    endfunction

    task automatic queue_tick(logic [1:0] op, logic [7:0] addr, logic [7:0] data, logic sda);
        tick_in_t t;
        t.op = op;
        t.mem_addr = addr;
        t.write_data = data;
        t.sda_in = sda;
        tick_feed.push_back(t);
    endtask

    // Waits, sampling at the falling edge, until every queued tick has been
    // taken and every expected result has come back.
    task automatic drain_all();
        @(negedge clk);
        while (tick_feed.size() != 0 || s_axis_tvalid || line_states.size() != 0)
            @(negedge clk);
    endtask

    // Feeds plain ticks until the predictor says the transfer in flight is
    // over, so that the block is idle at the end of every phase.
    task automatic finish_transfer(int ones_in_8);
        drain_all();
        while (bus_step != ST_IDLE)
        begin
            repeat (8)
                queue_tick(OP_TICK, 8'($urandom), 8'($urandom), pick_sda(ones_in_8));
            drain_all();
        end
    endtask

    task automatic write_reg(logic idx, logic [7:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DEVICE_ADDRESS)
            dev_addr = value[6:0];
        else
            ack_limit = value;
        @(negedge clk);
    endtask

    // New register setting between phases, while the block is idle.
    task automatic new_setting(logic [6:0] dev, logic [7:0] limit);
        repeat (2) @(negedge clk);
        write_reg(CFG_DEVICE_ADDRESS, {1'b0, dev});
        write_reg(CFG_ACK_TIMEOUT, limit);
    endtask

    // Random ticks. Roughly one tick in ten is a request, so a new transfer
    // starts soon after the previous one ends, and requests also land while
    // busy. ones_in_8 sets how often SDA reads high, which steers how many
    // acknowledges time out and what the read bytes look like.
    task automatic random_items(int count, int ones_in_8);
        int unsigned pick;
        logic [1:0]  code;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 19);
            code = (pick == 0) ? OP_WRITE : (pick == 1) ? OP_READ :
                   (pick == 2) ? OP_SPARE : OP_TICK;
            queue_tick(code, 8'($urandom), 8'($urandom), pick_sda(ones_in_8));
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset setting. Idle ticks, including the
        // spare op code, must keep both lines released.
        queue_tick(OP_SPARE, 8'hFF, 8'hFF, 1'b1);
        queue_tick(OP_TICK, 8'h00, 8'h00, 1'b0);

        // Byte write to the top address with zero data, every acknowledge
        // given at once. Requests that arrive mid-transfer must be ignored.
        queue_tick(OP_WRITE, 8'hFF, 8'h00, 1'b0);
        queue_tick(OP_READ, 8'h12, 8'h34, 1'b0);
        queue_tick(OP_WRITE, 8'h56, 8'h78, 1'b0);
        queue_tick(OP_SPARE, 8'h9A, 8'hBC, 1'b0);
        finish_transfer(0);

        // Random read of address zero with SDA held high: each acknowledge
        // waits out the full timeout of 255, the byte reads back as all ones
        // and the no-ack flag is latched.
        queue_tick(OP_READ, 8'h00, 8'hFF, 1'b1);
        finish_transfer(8);

        // A fresh read clears the no-ack flag and returns all zeros.
        queue_tick(OP_READ, 8'hA5, 8'h5A, 1'b0);
        finish_transfer(0);

        // Write of all ones to address zero with random acknowledges.
        queue_tick(OP_WRITE, 8'h00, 8'hFF, 1'b1);
        finish_transfer(4);

        // Highest device address with the shortest timeout. The receiver
        // holds off for a long stretch while the sender keeps offering.
        new_setting(7'h7F, 8'd1);
        random_items(80, 4);
        hold_req = 1'b1;
        finish_transfer(4);

        // Device address zero with the longest timeout, acknowledges mostly
        // given. Each phase boundary is a sender pause until all results
        // have come back.
        new_setting(7'h00, 8'd255);
        random_items(80, 2);
        finish_transfer(2);

        // Short timeouts with SDA mostly high, so many acknowledges are missed.
        new_setting(7'($urandom_range(0, 127)), 8'($urandom_range(2, 6)));
        random_items(80, 6);
        finish_transfer(6);

        new_setting(7'($urandom_range(0, 127)), 8'($urandom_range(1, 255)));
        random_items(80, 4);
        finish_transfer(4);

        // Last part of the run with no idling on either side.
        new_setting(7'($urandom_range(0, 127)), 8'($urandom_range(1, 8)));
        calm = 1'b1;
        random_items(80, 3);
        finish_transfer(3);

        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && line_states.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
